// File: design/smtb_pkg.sv
// ----------------------------------------------------------------------------
// smtb_pkg
// Shared types and constants of the sparse morph target blender.
// ----------------------------------------------------------------------------
`default_nettype none

package smtb_pkg;

  localparam int DEF_NUM_TARGETS  = 4;
  localparam int DEF_ENTRIES      = 1024;
  localparam int DEF_MAX_VERTICES = 65536;

  localparam int MAX_TGT  = 4;    // weight registers and issue lanes
  localparam int VW       = 16;   // vertex number
  localparam int PW       = 32;   // Q16.16 coordinate
  localparam int WW       = 16;   // Q2.14 weight
  localparam int IDXW     = 2;    // configuration register index
  localparam int CQ_DEPTH = 4;    // front to back command queue
  localparam int OQ_DEPTH = 8;    // result queue
  localparam int DIFF_W   = PW + 1;
  localparam int PROD_W   = WW + DIFF_W;
  localparam int TERM_W   = PROD_W - 14;
  localparam int SUM_W    = 40;

  typedef enum logic [1:0] {
    FN_LOAD   = 2'd0,
    FN_BLEND  = 2'd1,
    FN_REWIND = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  typedef struct packed {
    func_t         func;
    logic [1:0]    sel;
    logic [VW-1:0] ev;
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    logic [PW-1:0] z;
  } cmd_t;

  typedef struct packed {
    logic [VW-1:0] vtx;
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    logic [PW-1:0] z;
  } entry_t;

  typedef struct packed {
    logic [VW-1:0]                vtx;
    logic [PW-1:0]                bx;
    logic [PW-1:0]                by;
    logic [PW-1:0]                bz;
    logic [MAX_TGT-1:0]           en;
    logic [MAX_TGT-1:0][WW-1:0]   w;
    entry_t [MAX_TGT-1:0]         hd;
  } issue_t;

  typedef struct packed {
    logic [VW-1:0] vtx;
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    logic [PW-1:0] z;
    logic          sat;
  } result_t;

endpackage

`default_nettype wire

// File: design/smtb_ram.sv
// ----------------------------------------------------------------------------
// smtb_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module smtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wa,
  input  wire logic [WIDTH-1:0]                      wd,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ra,
  output logic      [WIDTH-1:0]                      rd
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    rd <= mem_r[ra];
  end

endmodule

`default_nettype wire

// File: design/smtb_front.sv
// ----------------------------------------------------------------------------
// smtb_front
// Accepts input beats, drops loads to absent targets, queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module smtb_front #(
  parameter int NUM_TARGETS = smtb_pkg::DEF_NUM_TARGETS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic [1:0]            in_func,
  input  wire logic [1:0]            in_target_select,
  input  wire logic [15:0]           in_entry_vertex,
  input  wire logic [31:0]           in_pos_x,
  input  wire logic [31:0]           in_pos_y,
  input  wire logic [31:0]           in_pos_z,
  output logic                       cmd_valid,
  output smtb_pkg::cmd_t             cmd,
  input  wire logic                  cmd_pop
);

  import smtb_pkg::*;

  localparam int CQ_AW = $clog2(CQ_DEPTH);
  localparam int CQ_CW = $clog2(CQ_DEPTH + 1);

  cmd_t             q_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wp_r;
  logic [CQ_AW-1:0] rp_r;
  logic [CQ_CW-1:0] cnt_r;
  logic             keep;
  logic             absent;
  cmd_t             in_cmd;

  assign in_full   = (cnt_r == CQ_CW'(CQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    in_cmd.func = func_t'(in_func);
    in_cmd.sel  = in_target_select;
    in_cmd.ev   = in_entry_vertex;
    in_cmd.x    = in_pos_x;
    in_cmd.y    = in_pos_y;
    in_cmd.z    = in_pos_z;
    // a load for a target that is not built has no effect
    absent = (in_cmd.func == FN_LOAD) && ({1'b0, in_target_select} >= 3'(NUM_TARGETS));
    keep   = in_push && !in_full && !absent;
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      q_r[wp_r] <= in_cmd;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (keep) begin
        wp_r <= wp_r + 1'b1;
      end
      if (cmd_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CQ_CW'(keep) - CQ_CW'(cmd_pop);
    end
  end

endmodule

`default_nettype wire

// File: design/smtb_back.sv
// ----------------------------------------------------------------------------
// smtb_back
// Weight registers, per-target tables with head/next registers, cursors,
// vertex counter and result credit; issues blend beats to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module smtb_back #(
  parameter int NUM_TARGETS  = smtb_pkg::DEF_NUM_TARGETS,
  parameter int ENTRIES      = smtb_pkg::DEF_ENTRIES,
  parameter int MAX_VERTICES = smtb_pkg::DEF_MAX_VERTICES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_data,
  input  wire logic                  cmd_valid,
  input  smtb_pkg::cmd_t             cmd,
  output logic                       cmd_pop,
  input  wire logic                  res_taken,
  output logic                       iss_valid_r,
  output smtb_pkg::issue_t           iss_r
);

  import smtb_pkg::*;

  localparam int FW   = $clog2(ENTRIES + 1);
  localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int EW   = $bits(entry_t);
  localparam int OQCW = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_REF1,
    ST_REF2
  } state_t;

  state_t            state_r;
  logic [WW-1:0]     weight_r [MAX_TGT];
  logic [VW-1:0]     vcnt_r;
  logic [OQCW-1:0]   out_cnt_r;
  logic              room;
  logic              go;
  logic              is_load;
  logic              is_blend;
  logic              is_rew;
  logic              is_clr;
  entry_t            ld_ent;
  logic [MAX_TGT-1:0] match_w;
  entry_t            head_w [MAX_TGT];

  assign room     = (out_cnt_r < OQCW'(OQ_DEPTH));
  assign go       = cmd_valid && (state_r == ST_RUN) && ((cmd.func != FN_BLEND) || room);
  assign cmd_pop  = go;
  assign is_load  = go && (cmd.func == FN_LOAD);
  assign is_blend = go && (cmd.func == FN_BLEND);
  assign is_rew   = go && (cmd.func == FN_REWIND);
  assign is_clr   = go && (cmd.func == FN_CLEAR);
  assign ld_ent   = entry_t'({cmd.ev, cmd.x, cmd.y, cmd.z});

  // rewind refetches the first two entries of every table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      case (state_r)
        ST_RUN:  if (is_rew) begin
          state_r <= ST_REF1;
        end
        ST_REF1: state_r <= ST_REF2;
        ST_REF2: state_r <= ST_RUN;
        default: state_r <= ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TGT; i++) begin
        weight_r[i] <= '0;
      end
      vcnt_r      <= '0;
      out_cnt_r   <= '0;
      iss_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        weight_r[cfg_index] <= cfg_data;
      end
      if (is_rew) begin
        vcnt_r <= '0;
      end else if (is_blend) begin
        vcnt_r <= (vcnt_r == VW'(MAX_VERTICES - 1)) ? '0 : vcnt_r + 1'b1;
      end
      out_cnt_r   <= out_cnt_r + OQCW'(is_blend) - OQCW'(res_taken);
      iss_valid_r <= is_blend;
    end
  end

  always_ff @(posedge clk) begin
    if (is_blend) begin
      iss_r.vtx <= vcnt_r;
      iss_r.bx  <= cmd.x;
      iss_r.by  <= cmd.y;
      iss_r.bz  <= cmd.z;
      iss_r.en  <= match_w;
      for (int i = 0; i < MAX_TGT; i++) begin
        iss_r.w[i]  <= weight_r[i];
        iss_r.hd[i] <= head_w[i];
      end
    end
  end

  for (genvar t = 0; t < MAX_TGT; t++) begin : g_tgt
    if (t < NUM_TARGETS) begin : g_on
      logic [FW-1:0]   fill_r;
      logic [FW-1:0]   cur_r;
      logic [FW-1:0]   cur_nxt;
      entry_t          head_r;
      entry_t          next_r;
      logic            byp_v_r;
      entry_t          byp_d_r;
      logic [EW-1:0]   rd_w;
      entry_t          ramq;
      logic            ld;
      logic            match;
      logic [FW+1:0]   ra_ext;
      logic [AW-1:0]   ra;
      logic [AW-1:0]   wa;

      assign ld    = is_load && (cmd.sel == 2'(t)) && (fill_r < FW'(ENTRIES));
      assign match = is_blend && (weight_r[t] != '0) && (cur_r < fill_r) &&
                     (head_r.vtx == vcnt_r);
      assign ramq  = byp_v_r ? byp_d_r : entry_t'(rd_w);
      assign wa    = fill_r[AW-1:0];
      assign match_w[t] = match;
      assign head_w[t]  = head_r;

      always_comb begin
        if (is_rew || is_clr) begin
          cur_nxt = '0;
        end else if (match) begin
          cur_nxt = cur_r + 1'b1;
        end else begin
          cur_nxt = cur_r;
        end
        // keep the entry two past the head in flight from the table
        if (is_rew) begin
          ra_ext = '0;
        end else if (state_r == ST_REF1) begin
          ra_ext = (FW+2)'(1);
        end else begin
          ra_ext = {2'b00, cur_nxt} + (FW+2)'(2);
        end
        ra = (ra_ext < (FW+2)'(ENTRIES)) ? ra_ext[AW-1:0] : '0;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          fill_r  <= '0;
          cur_r   <= '0;
          byp_v_r <= 1'b0;
        end else begin
          cur_r <= cur_nxt;
          if (is_clr) begin
            fill_r <= '0;
          end else if (ld) begin
            fill_r <= fill_r + 1'b1;
          end
          byp_v_r <= ld && (wa == ra);
        end
      end

      always_ff @(posedge clk) begin
        byp_d_r <= ld_ent;
        if (state_r == ST_REF1) begin
          head_r <= ramq;
        end else if (match) begin
          head_r <= next_r;
        end else if (ld && (fill_r == cur_r)) begin
          head_r <= ld_ent;
        end
        if ((state_r == ST_REF2) || match) begin
          next_r <= ramq;
        end else if (ld && ({1'b0, fill_r} == {1'b0, cur_r} + 1'b1)) begin
          next_r <= ld_ent;
        end
      end

      smtb_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
      ) u_tbl (
        .clk (clk),
        .we  (ld),
        .wa  (wa),
        .wd  (ld_ent),
        .ra  (ra),
        .rd  (rd_w)
      );
    end else begin : g_off
      assign match_w[t] = 1'b0;
      assign head_w[t]  = '0;
    end
  end

`ifndef SYNTHESIS
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r <= OQCW'(OQ_DEPTH))
    else $error("result credit overrun");
  a_refill_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> !cmd_pop)
    else $error("command taken during refetch");
  a_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && (cmd.func == FN_REWIND)) |=> (state_r == ST_REF1) && (vcnt_r == '0))
    else $error("rewind did not restart pass");
  a_issue: assert property (@(posedge clk) disable iff (!rst_n)
    iss_valid_r |-> $past(cmd_pop))
    else $error("issue without command");
`endif

endmodule

`default_nettype wire

// File: design/smtb_math.sv
// ----------------------------------------------------------------------------
// smtb_math
// Blend datapath: difference, multiply, round and pair sums, total, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module smtb_math (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          iss_valid,
  input  smtb_pkg::issue_t   iss,
  output logic               res_valid_r,
  output smtb_pkg::result_t  res_r
);

  import smtb_pkg::*;

  logic [4:1]               v_r;
  logic [VW-1:0]            vtx_r [1:4];
  logic signed [PW-1:0]     b1_r [3];
  logic signed [PW-1:0]     b2_r [3];
  logic signed [PW-1:0]     b3_r [3];
  logic [MAX_TGT-1:0]       en1_r;
  logic signed [WW-1:0]     w1_r [MAX_TGT];
  logic signed [DIFF_W-1:0] d1_r [MAX_TGT][3];
  logic signed [PROD_W-1:0] p2_r [MAX_TGT][3];
  logic signed [PROD_W-1:0] rp [MAX_TGT][3];
  logic signed [TERM_W-1:0] tm [MAX_TGT][3];
  logic signed [SUM_W-1:0]  sa3_r [3];
  logic signed [SUM_W-1:0]  sb3_r [3];
  logic signed [SUM_W-1:0]  tot4_r [3];
  logic [PW-1:0]            hc [MAX_TGT][3];
  logic [PW-1:0]            bc [3];

  always_comb begin
    bc[0] = iss.bx;
    bc[1] = iss.by;
    bc[2] = iss.bz;
    for (int t = 0; t < MAX_TGT; t++) begin
      hc[t][0] = iss.hd[t].x;
      hc[t][1] = iss.hd[t].y;
      hc[t][2] = iss.hd[t].z;
    end
    // round half up, then floor shift by 14
    for (int t = 0; t < MAX_TGT; t++) begin
      for (int c = 0; c < 3; c++) begin
        rp[t][c] = p2_r[t][c] + PROD_W'(8192);
        tm[t][c] = rp[t][c][PROD_W-1:14];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      res_valid_r <= 1'b0;
    end else begin
      v_r         <= {v_r[3:1], iss_valid};
      res_valid_r <= v_r[4];
    end
  end

  always_ff @(posedge clk) begin
    vtx_r[1] <= iss.vtx;
    vtx_r[2] <= vtx_r[1];
    vtx_r[3] <= vtx_r[2];
    vtx_r[4] <= vtx_r[3];
    en1_r    <= iss.en;
    for (int c = 0; c < 3; c++) begin
      b1_r[c] <= bc[c];
      b2_r[c] <= b1_r[c];
      b3_r[c] <= b2_r[c];
    end
    for (int t = 0; t < MAX_TGT; t++) begin
      w1_r[t] <= iss.w[t];
      for (int c = 0; c < 3; c++) begin
        d1_r[t][c] <= $signed({hc[t][c][PW-1], hc[t][c]}) -
                      $signed({bc[c][PW-1], bc[c]});
        if (en1_r[t]) begin
          p2_r[t][c] <= w1_r[t] * d1_r[t][c];
        end else begin
          p2_r[t][c] <= '0;
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      sa3_r[c]  <= SUM_W'(tm[0][c]) + SUM_W'(tm[1][c]);
      sb3_r[c]  <= SUM_W'(tm[2][c]) + SUM_W'(tm[3][c]);
      tot4_r[c] <= SUM_W'(b3_r[c]) + sa3_r[c] + sb3_r[c];
    end
  end

  always_ff @(posedge clk) begin
    logic [PW-1:0] cl [3];
    logic          sat;
    sat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      if (tot4_r[c] > SUM_W'(64'sd2147483647)) begin
        cl[c] = 32'h7FFF_FFFF;
        sat   = 1'b1;
      end else if (tot4_r[c] < -SUM_W'(64'sd2147483648)) begin
        cl[c] = 32'h8000_0000;
        sat   = 1'b1;
      end else begin
        cl[c] = tot4_r[c][PW-1:0];
      end
    end
    res_r.vtx <= vtx_r[4];
    res_r.x   <= cl[0];
    res_r.y   <= cl[1];
    res_r.z   <= cl[2];
    res_r.sat <= sat;
  end

endmodule

`default_nettype wire

// File: design/smtb_outq.sv
// ----------------------------------------------------------------------------
// smtb_outq
// Result queue; space is guaranteed by the credit count in the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module smtb_outq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  smtb_pkg::result_t  din,
  input  wire logic          pop,
  output logic               empty,
  output smtb_pkg::result_t  dout
);

  import smtb_pkg::*;

  localparam int AW = $clog2(OQ_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH + 1);

  result_t       mem_r [OQ_DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [CW-1:0] cnt_r;
  logic          take;

  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];
  assign take  = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (take) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(take);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CW'(OQ_DEPTH)) |-> !push || take)
    else $error("result queue overflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !take) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("result count slip");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> (wp_r == rp_r))
    else $error("pointers disagree on empty");
`endif

endmodule

`default_nettype wire

// File: design/sparse_morph_target_blend.sv
// path of an accepted beat: command queue, issue register, datapath, result queue
// throughput: one item per cycle while no rewind refetch runs and the result credit
// has room; each target's head/next registers and its table read port let every
// blend compare and advance all cursors at once; a rewind holds off commands while
// the first two entries are refetched; reset (synchronous, rst_n low): weights, fill
// counts, cursors, counter and queues clear; table contents are kept and not cleared
// ----------------------------------------------------------------------------
// sparse_morph_target_blend
// Sparse morph target vertex position blender, top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_morph_target_blend #(
  parameter int NUM_TARGETS  = smtb_pkg::DEF_NUM_TARGETS,
  parameter int ENTRIES      = smtb_pkg::DEF_ENTRIES,
  parameter int MAX_VERTICES = smtb_pkg::DEF_MAX_VERTICES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_func,
  input  wire logic [1:0]  in_target_select,
  input  wire logic [15:0] in_entry_vertex,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [15:0]      out_vertex,
  output logic [31:0]      out_x,
  output logic [31:0]      out_y,
  output logic [31:0]      out_z,
  output logic             out_saturated
);

  import smtb_pkg::*;

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;
  logic    iss_valid;
  issue_t  iss;
  logic    res_valid;
  result_t res;
  result_t head;

  smtb_front #(
    .NUM_TARGETS (NUM_TARGETS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_func          (in_func),
    .in_target_select (in_target_select),
    .in_entry_vertex  (in_entry_vertex),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop)
  );

  smtb_back #(
    .NUM_TARGETS  (NUM_TARGETS),
    .ENTRIES      (ENTRIES),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .res_taken   (out_pop && !out_empty),
    .iss_valid_r (iss_valid),
    .iss_r       (iss)
  );

  smtb_math u_math (
    .clk         (clk),
    .rst_n       (rst_n),
    .iss_valid   (iss_valid),
    .iss         (iss),
    .res_valid_r (res_valid),
    .res_r       (res)
  );

  smtb_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .din   (res),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (head)
  );

  assign out_vertex    = head.vtx;
  assign out_x         = head.x;
  assign out_y         = head.y;
  assign out_z         = head.z;
  assign out_saturated = head.sat;

endmodule

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the sparse morph target blender. It loads sparse target
// tables, streams base vertices and checks every blended position beat
// against a local predictor that keeps its own copy of the tables, the
// cursors, the vertex counter and the weights. Both channels idle at
// random, and one phase holds the result side off until the block stalls
// its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import smtb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT    = 4;
  localparam int DEPTH = 1024;
  localparam int LIMIT = 1500000;

  localparam logic [1:0] REG_WEIGHT_ZERO  = 2'd0;
  localparam logic [1:0] REG_WEIGHT_ONE   = 2'd1;
  localparam logic [1:0] REG_WEIGHT_TWO   = 2'd2;
  localparam logic [1:0] REG_WEIGHT_THREE = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_func = FN_BLEND;
  logic [1:0]  in_target_select = '0;
  logic [15:0] in_entry_vertex = '0;
  logic [31:0] in_pos_x = '0;
  logic [31:0] in_pos_y = '0;
  logic [31:0] in_pos_z = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [15:0] out_vertex;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic        out_saturated;

  sparse_morph_target_blend DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [15:0] tab_vtx [NT][DEPTH];
  int          tab_x [NT][DEPTH];
  int          tab_y [NT][DEPTH];
  int          tab_z [NT][DEPTH];
  int          fill [NT];
  int          cursor [NT];
  logic [15:0] vcount;
  shortint     weight [NT];

  result_t blended_q[$];
  int      errors = 0;
  int      cycles = 0;
  bit      quiet = 1'b0;     // no idling on either side
  logic    hold = 1'b0;      // result side held off
  int      pop_gap = 0;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return $urandom_range(0, 255) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic int clamp(longint v, ref logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return int'(v);
  endfunction

  function automatic longint term(shortint w, int tgt, int base);
    longint p;
    p = longint'(w) * (longint'(tgt) - longint'(base));
    return (p + 64'sd8192) >>> 14;
  endfunction

  function automatic void predict(logic [1:0] fn, logic [1:0] sel, logic [15:0] ev,
                                  logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    longint sx, sy, sz;
    int c;
    result_t r;
    logic sat;
    case (fn)
      FN_LOAD: begin
        if (fill[sel] < DEPTH) begin
          tab_vtx[sel][fill[sel]] = ev;
          tab_x[sel][fill[sel]] = px;
          tab_y[sel][fill[sel]] = py;
          tab_z[sel][fill[sel]] = pz;
          fill[sel]++;
        end
      end
      FN_REWIND: begin
        foreach (cursor[t]) cursor[t] = 0;
        vcount = '0;
      end
      FN_CLEAR: begin
        foreach (cursor[t]) begin
          cursor[t] = 0;
          fill[t] = 0;
        end
      end
      default: begin
        sx = longint'(int'(px));
        sy = longint'(int'(py));
        sz = longint'(int'(pz));
        for (int t = 0; t < NT; t++) begin
          c = cursor[t];
          if (weight[t] != 0 && c < fill[t] && tab_vtx[t][c] == vcount) begin
            sx += term(weight[t], tab_x[t][c], int'(px));
            sy += term(weight[t], tab_y[t][c], int'(py));
            sz += term(weight[t], tab_z[t][c], int'(pz));
            cursor[t] = c + 1;
          end
        end
        sat = 1'b0;
        r.vtx = vcount;
        r.x = clamp(sx, sat);
        r.y = clamp(sy, sat);
        r.z = clamp(sz, sat);
        r.sat = sat;
        blended_q.push_back(r);
        vcount++;
      end
    endcase
  endfunction

  task automatic send_item(logic [1:0] fn, logic [1:0] sel, logic [15:0] ev,
                           logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    int gap;
    in_push <= 1'b1;
    in_func <= fn;
    in_target_select <= sel;
    in_entry_vertex <= ev;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict(fn, sel, ev, px, py, pz);
    gap = rand_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic blend(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    send_item(FN_BLEND, 2'($urandom), 16'($urandom), px, py, pz);
  endtask

  task automatic load(logic [1:0] sel, logic [15:0] ev);
    send_item(FN_LOAD, sel, ev, rand_pos(), rand_pos(), rand_pos());
  endtask

  task automatic ctrl(logic [1:0] fn);
    send_item(fn, 2'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
  endtask

  // stop offering, then wait out all results and the pipeline
  task automatic drain();
    in_push <= 1'b0;
    while (blended_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_weight(logic [1:0] idx, shortint w);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    weight[idx] = w;
    @(posedge clk);
  endtask

  task automatic set_weights(shortint w0, shortint w1, shortint w2, shortint w3);
    write_weight(REG_WEIGHT_ZERO, w0);
    write_weight(REG_WEIGHT_ONE, w1);
    write_weight(REG_WEIGHT_TWO, w2);
    write_weight(REG_WEIGHT_THREE, w3);
  endtask

  // result side: check each accepted beat, then pick the next pop
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (out_pop && !out_empty) begin
      if (blended_q.size() == 0) begin
        $error("unexpected result beat vertex %0d", out_vertex);
        errors++;
      end else begin
        result_t e;
        e = blended_q.pop_front();
        if (out_vertex !== e.vtx) begin
          $error("out_vertex exp %0d got %0d", e.vtx, out_vertex);
          errors++;
        end
        if (out_x !== e.x) begin
          $error("out_x exp %h got %h", e.x, out_x);
          errors++;
        end
        if (out_y !== e.y) begin
          $error("out_y exp %h got %h", e.y, out_y);
          errors++;
        end
        if (out_z !== e.z) begin
          $error("out_z exp %h got %h", e.z, out_z);
          errors++;
        end
        if (out_saturated !== e.sat) begin
          $error("out_saturated exp %0d got %0d", e.sat, out_saturated);
          errors++;
        end
      end
      pop_gap = rand_gap();
    end
    if (hold) begin
      out_pop <= 1'b0;
    end else if (pop_gap > 0) begin
      out_pop <= 1'b0;
      pop_gap--;
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic test_directed();
    set_weights(16'sh7fff, -16'sh8000, 16'sh4000, 16'sh0001);
    // target 0 and 1 both hit vertex 0 with extreme targets
    send_item(FN_LOAD, 2'd0, 16'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    send_item(FN_LOAD, 2'd1, 16'd0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000);
    send_item(FN_LOAD, 2'd2, 16'd1, 32'h0000_2000, 32'hffff_e000, 32'h0000_6000);
    // out of order entry stalls target 3 at its head
    send_item(FN_LOAD, 2'd3, 16'd2, 32'h0100_0000, 32'h0000_0001, 32'hffff_ffff);
    send_item(FN_LOAD, 2'd3, 16'd1, 32'h0200_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(FN_LOAD, 2'd0, 16'hffff, 32'h1234_5678, 32'h0, 32'h0);
    blend(32'h8000_0000, 32'h7fff_ffff, 32'h0);
    blend(32'h0, 32'h0, 32'h0);
    blend(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    blend(32'h0, 32'h0, 32'h0);   // target 0 head names a vertex far ahead
    ctrl(FN_REWIND);
    blend(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    blend(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    blend(32'h0, 32'h0, 32'h0);   // target 3 matches; targets 1 and 2 are exhausted
    drain();
    // zero weights hold the cursors of targets 0, 1 and 3; target 2 blends with weight -1
    set_weights(16'sh0000, 16'sh0000, -16'sh0001, 16'sh0000);
    ctrl(FN_REWIND);
    blend(32'h0001_0000, 32'h0, 32'h0);
    blend(32'h0001_0000, 32'h0, 32'h0);
    drain();
    write_weight(REG_WEIGHT_ZERO, 16'sh2000);
    ctrl(FN_CLEAR);               // counter keeps counting
    send_item(FN_LOAD, 2'd0, 16'd2, 32'h0003_0000, 32'h0, 32'h0);
    blend(32'h0, 32'h0, 32'h0);
    drain();
  endtask

  task automatic random_pass(int n);
    logic [15:0] nxt [NT];
    int cnt;
    ctrl(FN_CLEAR);
    ctrl(FN_REWIND);
    foreach (nxt[t]) nxt[t] = 16'($urandom_range(0, 3));
    // sorted sparse entries, with a rare out of order one
    for (int i = 0; i < n / 3; i++) begin
      int t;
      t = $urandom_range(0, NT - 1);
      if ($urandom_range(0, 29) == 0) begin
        load(2'(t), 16'($urandom));
      end else begin
        load(2'(t), nxt[t]);
        nxt[t] = nxt[t] + 16'($urandom_range(0, 4));
      end
    end
    ctrl(FN_REWIND);
    cnt = n - n / 3;
    for (int i = 0; i < cnt; i++) begin
      case ($urandom_range(0, 39))
        0: ctrl(FN_REWIND);
        1: load(2'($urandom), 16'($urandom));
        default: blend(rand_pos(), rand_pos(), rand_pos());
      endcase
    end
    drain();
  endtask

  task automatic test_random();
    random_pass(240);
    set_weights(shortint'($urandom), shortint'($urandom), 16'sh0000,
                shortint'($urandom));
    random_pass(240);
    set_weights(-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff);
    random_pass(240);
    set_weights(shortint'($urandom_range(0, 63)), shortint'(-$urandom_range(1, 63)),
                shortint'($urandom), 16'sh4000);
    random_pass(240);
  endtask

  task automatic test_backpressure();
    set_weights(16'sh1000, 16'sh2000, 16'sh3000, 16'sh0800);
    quiet = 1'b1;
    ctrl(FN_CLEAR);
    ctrl(FN_REWIND);
    for (int i = 0; i < 12; i++) load(2'(i % NT), 16'(i / NT));
    ctrl(FN_REWIND);
    fork
      begin
        hold <= 1'b1;
        repeat (300) @(posedge clk);
        hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 60; i++) blend(rand_pos(), rand_pos(), rand_pos());
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    foreach (fill[t]) begin
      fill[t] = 0;
      cursor[t] = 0;
      weight[t] = 0;
    end
    vcount = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
